// File: hw/rtl/htfd_pkg.sv
`default_nettype none
package htfd_pkg;

    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [2:0] POS_FIRST = 3'd0;
    localparam logic [2:0] POS_LAST  = 3'd6;

    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic [11:0] TEMP_OFFSET = 12'd500;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    // CRC-8, MSB first, one byte folded in
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/htfd_if.sv
`default_nettype none
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [9:0]         humidity_tenths;
    logic signed [11:0] temperature_tenths;

    modport source (output valid, output frame_status, output humidity_tenths,
                    output temperature_tenths, input ready);
    modport sink   (input valid, input frame_status, input humidity_tenths,
                    input temperature_tenths, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/humidity_temperature_frame_decoder_core.sv
// Humidity/temperature sensor frame decoder.
// i_in carries one frame byte per beat (data_byte, frame_start); a frame is a
// status byte, five payload bytes and a CRC-8 byte (poly 0x31, init 0xFF).
// o_res carries one beat per completed frame: frame_status (ok, busy, CRC
// error), humidity_tenths and temperature_tenths (zero unless ok).
// frame_start restarts the frame at the byte it marks.
// Throughput: one input beat per cycle. Latency: the result beat is valid in
// the cycle after the seventh byte is accepted; CRC folding sits between the
// input and the frame state registers, the CRC compare and the scaling
// multipliers between the frame state registers and the result register.
// Reset (synchronous, active low) returns to the start of a frame and drops
// any pending result.
// When the receiver stalls, the result waits in the output register and
// i_in.ready stays low until it is taken, i.e. while o_res.valid is high and
// o_res.ready is low; no input beat is taken in those cycles.
`default_nettype none
module humidity_temperature_frame_decoder_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    htfd_in_if.sink      i_in,
    htfd_out_if.source   o_res
);

    logic [2:0]         r_pos, n_pos;
    logic [7:0]         r_crc, n_crc;
    logic               r_busy, n_busy;
    logic [39:0]        r_payload, n_payload;
    logic               r_out_vld;
    htfd_pkg::t_status  r_status;
    logic [9:0]         r_hum;
    logic signed [11:0] r_temp;

    logic               accept;
    logic               last_byte;
    logic [2:0]         pos_eff;
    htfd_pkg::t_status  sc_status;
    logic [9:0]         sc_hum;
    logic signed [11:0] sc_temp;

    assign i_in.ready = !r_out_vld || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_eff   = (i_in.frame_start || r_pos > htfd_pkg::POS_LAST)
                       ? htfd_pkg::POS_FIRST : r_pos;
    assign last_byte = (pos_eff == htfd_pkg::POS_LAST);

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_busy    = r_busy;
        n_payload = r_payload;
        if (pos_eff == htfd_pkg::POS_FIRST) begin
            n_crc     = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, i_in.data_byte);
            n_busy    = i_in.data_byte[7];
            n_payload = '0;
            n_pos     = pos_eff + 3'd1;
        end else if (!last_byte) begin
            n_crc     = htfd_pkg::crc8_feed(r_crc, i_in.data_byte);
            n_payload = {r_payload[31:0], i_in.data_byte};
            n_pos     = pos_eff + 3'd1;
        end else begin
            n_crc = htfd_pkg::CRC_INIT;
            n_pos = htfd_pkg::POS_FIRST;
        end
    end

    htfd_scale u_scale (
        .i_payload   (r_payload),
        .i_busy      (r_busy),
        .i_crc_match (r_crc == i_in.data_byte),
        .o_status    (sc_status),
        .o_hum       (sc_hum),
        .o_temp      (sc_temp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= htfd_pkg::POS_FIRST;
            r_crc     <= htfd_pkg::CRC_INIT;
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_busy <= n_busy;
            end
            if (accept && last_byte) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= n_payload;
        end
        if (accept && last_byte) begin
            r_status <= sc_status;
            r_hum    <= sc_hum;
            r_temp   <= sc_temp;
        end
    end

    assign o_res.valid              = r_out_vld;
    assign o_res.frame_status       = r_status;
    assign o_res.humidity_tenths    = r_hum;
    assign o_res.temperature_tenths = r_temp;

endmodule
`default_nettype wire

// File: hw/rtl/htfd_scale.sv
`default_nettype none
module htfd_scale (
    input  wire logic [39:0]        i_payload,
    input  wire logic               i_busy,
    input  wire logic               i_crc_match,
    output htfd_pkg::t_status       o_status,
    output logic [9:0]              o_hum,
    output logic signed [11:0]      o_temp
);

    logic [29:0] hum_prod;
    logic [30:0] temp_prod;
    logic [11:0] temp_val;

    assign hum_prod  = i_payload[39:20] * htfd_pkg::HUM_SCALE;
    assign temp_prod = i_payload[19:0] * htfd_pkg::TEMP_SCALE;
    assign temp_val  = {1'b0, temp_prod[30:20]} - htfd_pkg::TEMP_OFFSET;

    always_comb begin
        if (i_busy) begin
            o_status = htfd_pkg::ST_BUSY;
        end else if (!i_crc_match) begin
            o_status = htfd_pkg::ST_CRC_ERR;
        end else begin
            o_status = htfd_pkg::ST_OK;
        end
        // failed frames report zero readings
        if (o_status == htfd_pkg::ST_OK) begin
            o_hum  = hum_prod[29:20];
            o_temp = $signed(temp_val);
        end else begin
            o_hum  = '0;
            o_temp = '0;
        end
    end

endmodule
`default_nettype wire
